>>> design/ple_pkg.sv
// Shared types and codes for the positional list engine.
package ple_pkg;

  localparam int OP_W     = 2;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT    = 2'd0,
    OP_POP_FRONT = 2'd1,
    OP_POP_REAR  = 2'd2,
    OP_SEARCH    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_POS   = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD      = 3'd0,
    CELL_INSERT    = 3'd1,
    CELL_POP       = 3'd2,
    CELL_TRIM      = 3'd3,
    CELL_LOAD_KEY  = 3'd4,
    CELL_LOAD_REAR = 3'd5,
    CELL_SHIFT     = 3'd6
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     at;
    logic     after;
  } cell_ctrl_t;

  typedef struct packed {
    logic              occ;
    logic [DATA_W-1:0] value;
    logic              hit;
    logic [DATA_W-1:0] data;
  } cell_link_t;

endpackage

>>> design/ple_cell.sv
// One list cell: a stored value, its occupancy bit and a scan token stage.
module ple_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  ple_pkg::cell_ctrl_t      ctrl,
  input  logic [31:0]              din,
  input  ple_pkg::cell_link_t      prev,
  input  ple_pkg::cell_link_t      next,
  output ple_pkg::cell_link_t      self
);
  import ple_pkg::*;

  logic              occ;
  logic [DATA_W-1:0] value;
  logic              hit;
  logic [DATA_W-1:0] data;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
      hit <= 1'b0;
    end else begin
      unique case (ctrl.op)
        CELL_INSERT: begin
          if (ctrl.at) begin
            occ <= 1'b1;
          end else if (ctrl.after) begin
            occ <= prev.occ;
          end
        end
        CELL_POP, CELL_TRIM: occ <= next.occ;
        CELL_LOAD_KEY:  hit <= occ && (value == din);
        CELL_LOAD_REAR: hit <= occ && !next.occ;
        CELL_SHIFT:     hit <= next.hit;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      CELL_INSERT: begin
        if (ctrl.at) begin
          value <= din;
        end else if (ctrl.after) begin
          value <= prev.value;
        end
      end
      CELL_POP:                      value <= next.value;
      CELL_LOAD_KEY, CELL_LOAD_REAR: data <= value;
      CELL_SHIFT:                    data <= next.data;
      default: ;
    endcase
  end

  assign self = '{occ: occ, value: value, hit: hit, data: data};

endmodule

>>> design/positional_list_engine_top.sv
// Positional list engine: top level with the cell row, sequencer and result register.
//
// Holds an ordered list of up to DEPTH signed 32-bit values in a row of cells,
// cell 0 being the front. Insert at a position and remove-front need no scan:
// every cell shifts or loads in parallel. Search and remove-rear load a token
// into every cell at once (a key match, or the rear marker) and then shift the
// tokens toward the front one cell per cycle until the front sees a hit or, for a
// search, the scan reaches the last occupied cell. Every transfer on the input
// gives one result transfer; a new item is taken only when no scan runs and the
// output register is empty or hands its result over in the same cycle, so a
// waiting result holds the input.
module positional_list_engine_top #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // operation[1:0], value[33:2], position[40:34], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata   // status[2:0], value_out[34:3], found_position[41:35],
                                // count[48:42], zero pad
);
  import ple_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [IDX_W-1:0]   scan_idx, scan_idx_next;
  logic [DATA_W-1:0]  key;
  logic               scan_search;

  op_t                op;
  logic [DATA_W-1:0]  din;
  logic [POS_W-1:0]   pos;
  logic [CMP_W-1:0]   pos_w;
  logic [CMP_W-1:0]   cnt_w;
  logic               accept;
  logic               empty;
  logic               bad_pos;
  logic               full;

  cell_op_t           cell_op;
  logic               out_load;
  status_t            res_status;
  logic [DATA_W-1:0]  res_value;
  logic [POS_W-1:0]   res_fpos;

  cell_link_t         links [DEPTH];
  logic [DEPTH-1:0]   occ_vec;

  assign op      = op_t'(s_tdata[1:0]);
  assign din     = s_tdata[33:2];
  assign pos     = s_tdata[40:34];
  assign pos_w   = CMP_W'(pos);
  assign cnt_w   = CMP_W'(count);
  assign empty   = (count == '0);
  assign bad_pos = (pos == '0) || (pos_w > cnt_w + CMP_W'(1));
  assign full    = (cnt_w == CMP_W'(DEPTH));

  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctrl_t ctrl;
    cell_link_t prev_link;
    cell_link_t next_link;

    assign ctrl.op    = cell_op;
    assign ctrl.at    = (pos_w == CMP_W'(i) + CMP_W'(1));
    assign ctrl.after = (CMP_W'(i) >= pos_w);

    if (i == 0) begin : g_front
      assign prev_link = '0;
    end else begin : g_mid_prev
      assign prev_link = links[i-1];
    end

    if (i == DEPTH - 1) begin : g_rear
      assign next_link = '0;
    end else begin : g_mid_next
      assign next_link = links[i+1];
    end

    ple_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctrl (ctrl),
      .din  (din),
      .prev (prev_link),
      .next (next_link),
      .self (links[i])
    );

    assign occ_vec[i] = links[i].occ;
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    scan_idx_next = scan_idx;
    cell_op       = CELL_HOLD;
    out_load      = 1'b0;
    res_status    = ST_OK;
    res_value     = '0;
    res_fpos      = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_INSERT: begin
              out_load = 1'b1;
              if (bad_pos) begin
                res_status = ST_BAD_POS;
              end else if (full) begin
                res_status = ST_FULL;
              end else begin
                cell_op    = CELL_INSERT;
                count_next = count + CNT_W'(1);
              end
            end
            OP_POP_FRONT: begin
              out_load = 1'b1;
              if (empty) begin
                res_status = ST_EMPTY;
              end else begin
                cell_op    = CELL_POP;
                res_value  = links[0].value;
                count_next = count - CNT_W'(1);
              end
            end
            OP_POP_REAR: begin
              if (empty) begin
                out_load   = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                cell_op       = CELL_LOAD_REAR;
                scan_idx_next = '0;
                state_next    = S_SCAN;
              end
            end
            OP_SEARCH: begin
              if (empty) begin
                out_load   = 1'b1;
                res_status = ST_EMPTY;
                res_value  = din;
              end else begin
                cell_op       = CELL_LOAD_KEY;
                scan_idx_next = '0;
                state_next    = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (links[0].hit) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          if (scan_search) begin
            res_value = key;
            res_fpos  = POS_W'(scan_idx) + POS_W'(1);
          end else begin
            cell_op    = CELL_TRIM;
            res_value  = links[0].data;
            count_next = count - CNT_W'(1);
          end
        end else if (CNT_W'(scan_idx) + CNT_W'(1) == count) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          res_status = ST_NOT_FOUND;
          res_value  = key;
        end else begin
          cell_op       = CELL_SHIFT;
          scan_idx_next = scan_idx + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      scan_idx <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      scan_idx <= scan_idx_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key         <= din;
      scan_search <= (op == OP_SEARCH);
    end
    if (out_load) begin
      m_tdata <= {7'd0, POS_W'(count_next), res_fpos, res_value, res_status};
    end
  end

`ifndef SYNTHESIS
  a_front_occ: assert property (@(posedge clk) disable iff (rst)
    links[0].occ == (count != '0))
    else $error("front cell occupancy disagrees with count");

  a_occ_count: assert property (@(posedge clk) disable iff (rst)
    $countones(occ_vec) == int'(count))
    else $error("occupied cells disagree with count");

  a_scan_out_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !m_tvalid)
    else $error("result register busy during scan");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (CNT_W'(scan_idx) < count))
    else $error("scan ran past the last occupied cell");

  a_scan_entry: assert property (@(posedge clk) disable iff (rst)
    (accept && !empty && (op == OP_SEARCH || op == OP_POP_REAR)) |=> (state == S_SCAN))
    else $error("search or rear removal did not start a scan");
`endif

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the positional list engine: directed table, then random list traffic.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ple_pkg::*;

  localparam int DEPTH        = 64;
  localparam int N_DIRECTED   = 21;
  localparam int N_RANDOM     = 880;
  localparam int SEG_LEN      = 70;
  localparam int QUIET_TAIL   = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam int CYCLE_LIMIT  = 600000;

  typedef struct packed {
    status_t         status;
    logic [31:0]     value;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] count;
  } list_result_t;

  typedef struct packed {
    op_t              op;
    logic [31:0]      value;
    logic [POS_W-1:0] position;
    logic             typed;
    list_result_t     res;
  } list_row_t;

  localparam list_result_t NO_RES = '{ST_OK, 32'h0, 7'd0, 7'd0};

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;

  logic [31:0]  list_vals [0:DEPTH-1];
  int           list_len;
  list_result_t expected_results [$];
  list_row_t    directed_rows [0:N_DIRECTED-1];
  logic [31:0]  value_pool [0:7];

  int error_count;
  int results_checked;
  int items_sent;
  int peak_len;
  int status_hits [0:4];
  int cycle_count;
  int gap_pct;
  bit quiet_tail;
  int hold_asks;
  int holds_seen;
  int sink_wait;

  positional_list_engine_top #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #4 clk = ~clk;

  function automatic list_result_t apply_list_op(input op_t op, input logic [31:0] val,
                                                 input logic [POS_W-1:0] pos);
    list_result_t r;
    int           k;
    int           p;
    r = NO_RES;
    p = int'(pos);
    case (op)
      OP_INSERT: begin
        if (p == 0 || p > list_len + 1) begin
          r.status = ST_BAD_POS;
        end else if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (k = list_len; k > p - 1; k--) list_vals[k] = list_vals[k-1];
          list_vals[p-1] = val;
          list_len++;
        end
      end
      OP_POP_FRONT: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.value = list_vals[0];
          for (k = 1; k < list_len; k++) list_vals[k-1] = list_vals[k];
          list_len--;
        end
      end
      OP_POP_REAR: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.value = list_vals[list_len-1];
          list_len--;
        end
      end
      default: begin
        r.value = val;
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (k = 0; k < list_len; k++) if (list_vals[k] == val) break;
          if (k < list_len) r.position = 7'(k + 1);
          else r.status = ST_NOT_FOUND;
        end
      end
    endcase
    r.count = 7'(list_len);
    return r;
  endfunction

  task automatic send_list_op(input op_t op, input logic [31:0] val,
                              input logic [POS_W-1:0] pos, input logic typed,
                              input list_result_t typed_res);
    list_result_t r;
    int           gap;
    if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 17);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, pos, val, op};
    do @(posedge clk); while (!s_tready);
    r = apply_list_op(op, val, pos);
    status_hits[r.status]++;
    if (list_len > peak_len) peak_len = list_len;
    expected_results.push_back(typed ? typed_res : r);
    items_sent++;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
      $display("positional_list_engine_top: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    list_result_t exp_res;
    list_result_t got;
    got = list_result_t'({m_tdata[2:0], m_tdata[34:3], m_tdata[41:35], m_tdata[48:42]});
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, actual %p", $time, got);
        error_count++;
      end else begin
        exp_res = expected_results.pop_front();
        results_checked++;
        if (got.status !== exp_res.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_res.status, got.status);
          error_count++;
        end
        if (got.value !== exp_res.value) begin
          $display("%0t: value_out expected %h actual %h", $time, exp_res.value, got.value);
          error_count++;
        end
        if (got.position !== exp_res.position) begin
          $display("%0t: found_position expected %0d actual %0d", $time,
                   exp_res.position, got.position);
          error_count++;
        end
        if (got.count !== exp_res.count) begin
          $display("%0t: count expected %0d actual %0d", $time, exp_res.count, got.count);
          error_count++;
        end
      end
    end
    if (hold_asks != holds_seen) begin
      holds_seen <= hold_asks;
      sink_wait  <= HOLD_CYCLES;
      m_tready   <= 1'b0;
    end else if (sink_wait > 0) begin
      sink_wait <= sink_wait - 1;
      m_tready  <= 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
      sink_wait <= $urandom_range(1, 17) - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin
    int               i;
    int               seg;
    int               fill_pct;
    int               pick;
    op_t              op;
    logic [31:0]      val;
    logic [POS_W-1:0] pos;

    value_pool = '{32'h0000_0000, 32'h0000_0001, 32'hffff_ffff, 32'h7fff_ffff,
                   32'h8000_0000, 32'h0000_00ff, 32'hdead_beef, 32'h5555_aaaa};
    directed_rows = '{
      '{OP_POP_FRONT, 32'h0000_0000, 7'd0,   1'b1, '{ST_EMPTY, 32'h0, 7'd0, 7'd0}},
      '{OP_POP_REAR,  32'h0000_0000, 7'd0,   1'b1, '{ST_EMPTY, 32'h0, 7'd0, 7'd0}},
      '{OP_SEARCH,    32'h8000_0000, 7'd0,   1'b1, '{ST_EMPTY, 32'h8000_0000, 7'd0, 7'd0}},
      '{OP_INSERT,    32'h0000_0005, 7'd0,   1'b1, '{ST_BAD_POS, 32'h0, 7'd0, 7'd0}},
      '{OP_INSERT,    32'h0000_0005, 7'd2,   1'b1, '{ST_BAD_POS, 32'h0, 7'd0, 7'd0}},
      '{OP_INSERT,    32'h7fff_ffff, 7'd1,   1'b1, '{ST_OK, 32'h0, 7'd0, 7'd1}},
      '{OP_INSERT,    32'h8000_0000, 7'd2,   1'b1, '{ST_OK, 32'h0, 7'd0, 7'd2}},
      '{OP_INSERT,    32'hffff_ffff, 7'd1,   1'b1, '{ST_OK, 32'h0, 7'd0, 7'd3}},
      '{OP_INSERT,    32'h0000_0000, 7'd127, 1'b1, '{ST_BAD_POS, 32'h0, 7'd0, 7'd3}},
      '{OP_INSERT,    32'h0000_0000, 7'd5,   1'b1, '{ST_BAD_POS, 32'h0, 7'd0, 7'd3}},
      '{OP_INSERT,    32'h0000_0000, 7'd2,   1'b0, NO_RES},
      '{OP_SEARCH,    32'h8000_0000, 7'd0,   1'b0, NO_RES},
      '{OP_SEARCH,    32'h1234_5678, 7'd0,   1'b1, '{ST_NOT_FOUND, 32'h1234_5678, 7'd0, 7'd4}},
      '{OP_INSERT,    32'hffff_ffff, 7'd5,   1'b0, NO_RES},
      '{OP_SEARCH,    32'hffff_ffff, 7'd0,   1'b0, NO_RES},
      '{OP_POP_REAR,  32'h0000_0000, 7'd0,   1'b0, NO_RES},
      '{OP_POP_FRONT, 32'h0000_0000, 7'd0,   1'b0, NO_RES},
      '{OP_SEARCH,    32'h7fff_ffff, 7'd0,   1'b0, NO_RES},
      '{OP_INSERT,    32'haaaa_aaaa, 7'd64,  1'b1, '{ST_BAD_POS, 32'h0, 7'd0, 7'd3}},
      '{OP_INSERT,    32'h5555_5555, 7'd4,   1'b0, NO_RES},
      '{OP_POP_REAR,  32'hffff_ffff, 7'd127, 1'b0, NO_RES}
    };

    foreach (list_vals[k]) list_vals[k] = '0;
    foreach (status_hits[k]) status_hits[k] = 0;
    list_len = 0;
    fill_pct = 50;
    gap_pct  = 20;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < N_DIRECTED; i++) begin
      send_list_op(directed_rows[i].op, directed_rows[i].value, directed_rows[i].position,
                   directed_rows[i].typed, directed_rows[i].res);
    end

    for (i = 0; i < N_RANDOM; i++) begin
      if (i % SEG_LEN == 0) begin
        seg = i / SEG_LEN;
        if (seg == 2 || seg == 3 || seg == 9) fill_pct = 100;
        else if (seg == 4 || seg == 5) fill_pct = 0;
        else fill_pct = $urandom_range(15, 85);
        gap_pct = (seg % 4 == 1) ? 0 : $urandom_range(5, 30);
      end
      if (i == N_RANDOM - QUIET_TAIL) quiet_tail = 1'b1;
      if (i == 200) hold_asks++;
      if (i == 450) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
      end

      pick = $urandom_range(0, 99);
      val  = $urandom;
      pos  = 7'($urandom_range(0, 127));
      if (pick < 8) begin
        op = op_t'($urandom_range(0, 3));
      end else if ($urandom_range(0, 99) < fill_pct) begin
        op   = OP_INSERT;
        pick = $urandom_range(0, 3);
        pos  = (pick == 0) ? 7'd1 :
               (pick == 1) ? 7'(list_len + 1) : 7'($urandom_range(1, list_len + 1));
        if ($urandom_range(0, 1)) val = value_pool[$urandom_range(0, 7)];
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 3) op = OP_POP_FRONT;
        else if (pick < 6) op = OP_POP_REAR;
        else begin
          op = OP_SEARCH;
          if (list_len > 0 && $urandom_range(0, 9) < 7)
            val = list_vals[$urandom_range(0, list_len - 1)];
          else if ($urandom_range(0, 1))
            val = value_pool[$urandom_range(0, 7)];
        end
      end
      send_list_op(op, val, pos, 1'b0, NO_RES);
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results from %0d transfers; peak fill %0d of %0d.",
             results_checked, items_sent, peak_len, DEPTH);
    $display("Outcomes: ok %0d, bad position %0d, empty %0d, not found %0d, full %0d.",
             status_hits[ST_OK], status_hits[ST_BAD_POS], status_hits[ST_EMPTY],
             status_hits[ST_NOT_FOUND], status_hits[ST_FULL]);
    if (error_count == 0) begin
      $display("positional_list_engine_top: match");
    end else begin
      $display("positional_list_engine_top: mismatch");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/ple_pkg.sv
design/ple_cell.sv
design/positional_list_engine_top.sv
bench/tb_top.sv
